[hdl/rlf_pkg.sv]
package rlf_pkg;

  localparam int COLOR_W = 8;
  localparam int STEP_W  = 16;
  localparam int TICK_W  = 16;
  localparam int IDX_W   = 17;
  localparam int ACC_W   = 24;
  localparam int RGB_W   = 24;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;
  localparam int DIG_W   = 3;

  localparam logic [DIG_W-1:0]  DIG_LAST          = 3'd7;
  localparam logic [TICK_W-1:0] TICK_MAX          = 16'hFFFF;
  localparam logic [STEP_W-1:0] STEP_COUNT_RST    = 16'd255;
  localparam logic [TICK_W-1:0] TICK_INTERVAL_RST = 16'd10;

  // register select is address bit 2
  localparam logic REG_STEP_COUNT    = 1'b0;
  localparam logic REG_TICK_INTERVAL = 1'b1;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_HOLD
  } rlf_state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
  } rlf_lane_ctl_t;

  typedef struct packed {
    logic [STEP_W-1:0] step_count;
    logic [TICK_W-1:0] tick_interval;
  } rlf_cfg_t;

endpackage

[hdl/rlf_if.sv]
interface rlf_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] target_red;
  logic [7:0] target_green;
  logic [7:0] target_blue;

  modport source (output valid, func, target_red, target_green, target_blue, input ready);
  modport sink   (input valid, func, target_red, target_green, target_blue, output ready);
endinterface

interface rlf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       fade_done;

  modport source (output valid, out_red, out_green, out_blue, fade_done, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, fade_done, output ready);
endinterface

[hdl/rlf_regs.sv]
module rlf_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rlf_pkg::ADDR_W-1:0]    paddr,
  input  logic [rlf_pkg::DATA_W-1:0]    pwdata,
  output logic [rlf_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output rlf_pkg::rlf_cfg_t             cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_count    <= rlf_pkg::STEP_COUNT_RST;
      cfg.tick_interval <= rlf_pkg::TICK_INTERVAL_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        rlf_pkg::REG_STEP_COUNT: begin
          cfg.step_count <= pwdata[rlf_pkg::STEP_W-1:0];
        end
        rlf_pkg::REG_TICK_INTERVAL: begin
          cfg.tick_interval <= pwdata[rlf_pkg::TICK_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rlf_pkg::REG_STEP_COUNT: begin
        prdata = {{(rlf_pkg::DATA_W-rlf_pkg::STEP_W){1'b0}}, cfg.step_count};
      end
      rlf_pkg::REG_TICK_INTERVAL: begin
        prdata = {{(rlf_pkg::DATA_W-rlf_pkg::TICK_W){1'b0}}, cfg.tick_interval};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

[hdl/rlf_lane.sv]
// One color channel: MSB-first shift-add multiply of both weights, then
// restoring divide one quotient bit per cycle, all in one 24-bit register.
module rlf_lane (
  input  logic                           clk,
  input  rlf_pkg::rlf_lane_ctl_t         ctl,
  input  logic [rlf_pkg::COLOR_W-1:0]    from,
  input  logic [rlf_pkg::COLOR_W-1:0]    to,
  input  logic [rlf_pkg::STEP_W-1:0]     a,
  input  logic [rlf_pkg::STEP_W-1:0]     b,
  input  logic [rlf_pkg::STEP_W-1:0]     steps,
  output logic [rlf_pkg::COLOR_W-1:0]    quot
);

  logic [rlf_pkg::ACC_W-1:0]   acc;
  logic [rlf_pkg::COLOR_W-1:0] fsh;
  logic [rlf_pkg::COLOR_W-1:0] tsh;
  logic [rlf_pkg::ACC_W-1:0]   term_a;
  logic [rlf_pkg::ACC_W-1:0]   term_b;
  logic [rlf_pkg::STEP_W:0]    trial;
  logic [rlf_pkg::STEP_W:0]    diff;
  logic                        ge;

  always_comb begin
    term_a = fsh[rlf_pkg::COLOR_W-1] ? {{(rlf_pkg::ACC_W-rlf_pkg::STEP_W){1'b0}}, a} : '0;
    term_b = tsh[rlf_pkg::COLOR_W-1] ? {{(rlf_pkg::ACC_W-rlf_pkg::STEP_W){1'b0}}, b} : '0;
    trial  = acc[rlf_pkg::ACC_W-1:rlf_pkg::COLOR_W-1];
    ge     = trial >= {1'b0, steps};
    diff   = trial - {1'b0, steps};
  end

  always_ff @(posedge clk) begin
    priority if (ctl.load) begin
      acc <= '0;
      fsh <= from;
      tsh <= to;
    end else if (ctl.mul) begin
      acc <= {acc[rlf_pkg::ACC_W-2:0], 1'b0} + term_a + term_b;
      fsh <= {fsh[rlf_pkg::COLOR_W-2:0], 1'b0};
      tsh <= {tsh[rlf_pkg::COLOR_W-2:0], 1'b0};
    end else if (ctl.div) begin
      // remainder stays below steps, so 16 bits hold it
      acc <= {(ge ? diff[rlf_pkg::STEP_W-1:0] : trial[rlf_pkg::STEP_W-1:0]),
              acc[rlf_pkg::COLOR_W-2:0], ge};
    end else begin
      acc <= acc;
    end
  end

  // zero steps: the blend is the target itself
  assign quot = (steps == '0) ? to : acc[rlf_pkg::COLOR_W-1:0];

endmodule

[hdl/rgb_linear_fade.sv]
// Linear RGB fader.
// items channel: func 0 is a one millisecond tick, func 1 starts a fade to
// target_red/green/blue from the colour last emitted. results channel: one
// transfer per tick that updates the colour, with fade_done on the last step.
// APB port: step_count at 0x0, tick_interval at 0x4; write only while idle.
// Start items and ticks that do not update are taken while idle and keep it idle.
// An updating tick loads the lanes, then runs a bit-serial multiply and a
// bit-serial divide in three channel lanes side by side, then waits in the
// hold state until the output register is free and loads it.
// Ready drops for that whole span.
// The output register frees the input side: a new item is taken while a
// result waits. If a second update finishes while the receiver still stalls
// the first, the block holds it and stays busy until the first transfers.
// Reset (synchronous) sets step_count 255, tick_interval 10, stops fading,
// clears the elapsed count and the index, sets all colours to black and
// empties the output register.
module rgb_linear_fade (
  input  logic                          clk,
  input  logic                          rst,
  rlf_in_if.sink                        items,
  rlf_out_if.source                     results,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rlf_pkg::ADDR_W-1:0]    paddr,
  input  logic [rlf_pkg::DATA_W-1:0]    pwdata,
  output logic [rlf_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  rlf_pkg::rlf_cfg_t      cfg;
  rlf_pkg::rlf_state_t    state;
  rlf_pkg::rlf_state_t    state_next;
  rlf_pkg::rlf_lane_ctl_t lane_ctl;

  logic [rlf_pkg::DIG_W-1:0]   cnt;
  logic                        fading;
  logic [rlf_pkg::TICK_W-1:0]  tsu;
  logic [rlf_pkg::TICK_W-1:0]  tsu_inc;
  logic [rlf_pkg::IDX_W-1:0]   idx;
  logic [rlf_pkg::IDX_W-1:0]   idx_inc;
  logic [rlf_pkg::STEP_W-1:0]  idx_eff;
  logic [rlf_pkg::RGB_W-1:0]   start_colour;
  logic [rlf_pkg::RGB_W-1:0]   end_colour;
  logic [rlf_pkg::RGB_W-1:0]   cur_colour;
  logic [rlf_pkg::STEP_W-1:0]  wa;
  logic [rlf_pkg::STEP_W-1:0]  wb;
  logic [rlf_pkg::COLOR_W-1:0] q_red;
  logic [rlf_pkg::COLOR_W-1:0] q_green;
  logic [rlf_pkg::COLOR_W-1:0] q_blue;
  logic                        done_w;
  logic                        accept;
  logic                        go_update;
  logic                        slot_free;
  logic                        commit;
  logic                        out_valid;
  logic [rlf_pkg::COLOR_W-1:0] out_r;
  logic [rlf_pkg::COLOR_W-1:0] out_g;
  logic [rlf_pkg::COLOR_W-1:0] out_b;
  logic                        out_done;

  rlf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rlf_lane u_lane_red (
    .clk   (clk),
    .ctl   (lane_ctl),
    .from  (start_colour[23:16]),
    .to    (end_colour[23:16]),
    .a     (wa),
    .b     (wb),
    .steps (cfg.step_count),
    .quot  (q_red)
  );

  rlf_lane u_lane_green (
    .clk   (clk),
    .ctl   (lane_ctl),
    .from  (start_colour[15:8]),
    .to    (end_colour[15:8]),
    .a     (wa),
    .b     (wb),
    .steps (cfg.step_count),
    .quot  (q_green)
  );

  rlf_lane u_lane_blue (
    .clk   (clk),
    .ctl   (lane_ctl),
    .from  (start_colour[7:0]),
    .to    (end_colour[7:0]),
    .a     (wa),
    .b     (wb),
    .steps (cfg.step_count),
    .quot  (q_blue)
  );

  always_comb begin
    tsu_inc = (tsu == rlf_pkg::TICK_MAX) ? tsu : tsu + 1'b1;
    // index clamped to the step count when the count was lowered mid-fade
    idx_eff = (idx > {1'b0, cfg.step_count}) ? cfg.step_count
                                             : idx[rlf_pkg::STEP_W-1:0];
    idx_inc = idx + 1'b1;
    done_w  = idx_inc > {1'b0, cfg.step_count};
  end

  // outputs of the sequencer
  always_comb begin
    items.ready   = (state == rlf_pkg::S_IDLE);
    accept        = items.valid && items.ready;
    go_update     = accept && (items.func == rlf_pkg::FUNC_TICK) && fading &&
                    (tsu_inc > cfg.tick_interval);
    slot_free     = !out_valid || results.ready;
    commit        = (state == rlf_pkg::S_HOLD) && slot_free;
    lane_ctl.load = go_update;
    lane_ctl.mul  = (state == rlf_pkg::S_MUL);
    lane_ctl.div  = (state == rlf_pkg::S_DIV);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rlf_pkg::S_IDLE: begin
        if (go_update) state_next = rlf_pkg::S_MUL;
      end
      rlf_pkg::S_MUL: begin
        if (cnt == rlf_pkg::DIG_LAST) state_next = rlf_pkg::S_DIV;
      end
      rlf_pkg::S_DIV: begin
        if (cnt == rlf_pkg::DIG_LAST) state_next = rlf_pkg::S_HOLD;
      end
      rlf_pkg::S_HOLD: begin
        if (slot_free) state_next = rlf_pkg::S_IDLE;
      end
      default: begin
        state_next = rlf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rlf_pkg::S_IDLE;
      cnt          <= '0;
      fading       <= 1'b0;
      tsu          <= '0;
      idx          <= '0;
      start_colour <= '0;
      end_colour   <= '0;
      cur_colour   <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (go_update) begin
        cnt <= '0;
      end else if (lane_ctl.mul || lane_ctl.div) begin
        cnt <= cnt + 1'b1;
      end
      if (accept && (items.func == rlf_pkg::FUNC_START)) begin
        fading       <= 1'b1;
        start_colour <= cur_colour;
        end_colour   <= {items.target_red, items.target_green, items.target_blue};
        idx          <= '0;
      end else if (go_update) begin
        tsu <= '0;
      end else if (accept) begin
        tsu <= tsu_inc;
      end
      if (commit) begin
        cur_colour <= {q_red, q_green, q_blue};
        idx        <= done_w ? '0 : idx_inc;
        fading     <= !done_w;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go_update) begin
      wa <= cfg.step_count - idx_eff;
      wb <= idx_eff;
    end
    if (commit) begin
      out_r    <= q_red;
      out_g    <= q_green;
      out_b    <= q_blue;
      out_done <= done_w;
    end
  end

  assign results.valid     = out_valid;
  assign results.out_red   = out_r;
  assign results.out_green = out_g;
  assign results.out_blue  = out_b;
  assign results.fade_done = out_done;

  a_update_clears_elapsed: assert property (@(posedge clk) disable iff (rst)
    go_update |=> (tsu == '0) && (state == rlf_pkg::S_MUL))
    else $error("elapsed count not restarted on update");

  a_idle_tick_no_work: assert property (@(posedge clk) disable iff (rst)
    (accept && !fading) |=> (state == rlf_pkg::S_IDLE))
    else $error("work started while not fading");

  a_div_to_hold: assert property (@(posedge clk) disable iff (rst)
    ((state == rlf_pkg::S_DIV) && (cnt == rlf_pkg::DIG_LAST)) |=>
      (state == rlf_pkg::S_HOLD))
    else $error("divide did not end after eight digits");

  a_commit_loads_result: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid && (state == rlf_pkg::S_IDLE))
    else $error("finished update not presented");

  a_done_stops_fade: assert property (@(posedge clk) disable iff (rst)
    (commit && done_w) |=> !fading && (idx == '0) && out_done)
    else $error("final step did not stop fading");

endmodule
